>>> hdl/nrmc_pkg.sv
// Package for the NMEA RMC sentence parser: character codes, field numbers,
// number-parse constants and the reciprocal factors of the conversion pipeline.
// No dependencies; every other file of the block imports it.
`default_nettype none

package nrmc_pkg;

  // Character limits of the text and number fields.
  localparam int TIME_CHARS   = 6;
  localparam int LAT_CHARS    = 9;
  localparam int LON_CHARS    = 10;
  localparam int COURSE_CHARS = 7;
  localparam int TIME_LIM     = (TIME_CHARS < 6) ? TIME_CHARS : 6;
  localparam int COURSE_LIM   = (COURSE_CHARS < 7) ? COURSE_CHARS : 7;

  // ASCII codes.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam logic [2:0] HDR_LAST = 3'd5;

  // Field numbers, counted in commas after the header.
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_COURSE = 4'd8;
  localparam logic [3:0] CNT_MAX    = 4'd15;

  // Number parse phase: integer part, then one plus the fraction digits taken.
  localparam logic [2:0] PH_INT  = 3'd0;
  localparam logic [2:0] PH_FRAC = 3'd1;
  localparam logic [2:0] PH_DONE = 3'd7;

  localparam logic [2:0] POS_FRAC = 3'd4;
  localparam logic [2:0] SPD_FRAC = 3'd2;

  localparam int ACC_W = 30;
  localparam int SPD_W = 24;

  localparam logic [ACC_W-1:0] POS_CAP = 30'd999999999;
  localparam logic [ACC_W-1:0] SPD_CAP = 30'd9999999;

  localparam logic [19:0] LAT_MAX = 20'd900000;
  localparam logic [20:0] LON_MAX = 21'd1800000;
  localparam logic [17:0] SPD_MAX = 18'd185200;

  // Above this many hundredths of a knot the speed always saturates.
  localparam logic [SPD_W-1:0] SPD_SAT_KNOTS = 24'd100000;

  // Reciprocals: floor(v / d) = (v * ceil(2^k / d)) >> k over the value ranges used.
  localparam logic [30:0] RECIP_1E6 = 31'd1125899907;  // k = 50, v < 2^30
  localparam logic [28:0] RECIP_1E3 = 29'd274877907;   // k = 38, v < 2^28
  localparam logic [20:0] RECIP_60  = 21'd1118482;     // k = 26, v < 2^20

  typedef logic [ACC_W-1:0] acc_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    case (pos)
      3'd0:    hdr_byte = 8'h24;  // '$'
      3'd1:    hdr_byte = 8'h47;  // 'G'
      3'd2:    hdr_byte = 8'h50;  // 'P'
      3'd3:    hdr_byte = 8'h52;  // 'R'
      3'd4:    hdr_byte = 8'h4D;  // 'M'
      3'd5:    hdr_byte = 8'h43;  // 'C'
      default: hdr_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] n);
    case (n)
      3'd0:    pow10 = 14'd1;
      3'd1:    pow10 = 14'd10;
      3'd2:    pow10 = 14'd100;
      3'd3:    pow10 = 14'd1000;
      3'd4:    pow10 = 14'd10000;
      default: pow10 = 14'd1;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> hdl/nrmc_if.sv
// Valid/ready stream interfaces of the NMEA RMC parser: received characters in,
// decoded sentence reports out. Depends on nrmc_pkg.
`default_nettype none

interface nrmc_rx_if;
  import nrmc_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_report_if;
  import nrmc_pkg::*;
  logic        valid;
  logic        ready;
  logic        fix_valid;
  logic [47:0] utc_time_text;
  logic [19:0] lat_deg_e4;
  logic [7:0]  lat_hemisphere;
  logic [20:0] lon_deg_e4;
  logic [7:0]  lon_hemisphere;
  logic [17:0] speed_kmh_e2;
  logic [55:0] course_text;
  modport source (output valid, output fix_valid, output utc_time_text, output lat_deg_e4,
                  output lat_hemisphere, output lon_deg_e4, output lon_hemisphere,
                  output speed_kmh_e2, output course_text, input ready);
  modport sink   (input valid, input fix_valid, input utc_time_text, input lat_deg_e4,
                  input lat_hemisphere, input lon_deg_e4, input lon_hemisphere,
                  input speed_kmh_e2, input course_text, output ready);
endinterface

`default_nettype wire

>>> hdl/nmea_rmc_sentence_parser.sv
// NMEA RMC sentence parser: per-character field parser and a four-stage
// conversion pipeline feeding the report register. Depends on nrmc_pkg, nrmc_if.
//
//   channel   modport                  payload
//   rx        nrmc_rx_if.sink          rx_byte
//   report    nrmc_report_if.source    fix, time, lat, lon, speed, course
//
// One character is taken every cycle while rx.ready is high. A newline in a
// sentence loads the snapshot stage; its report is valid at the report register.
// Synchronous reset empties all stages and restarts the header hunt.
// rx.ready drops only while the snapshot stage, the three conversion stages
// and the report register are all full and report.ready is low.
`default_nettype none

module nmea_rmc_sentence_parser (
  input  logic                 clk,
  input  logic                 rst,
  nrmc_rx_if.sink              rx,
  nrmc_report_if.source        report
);
  import nrmc_pkg::*;

  // Parser state.
  logic [2:0]  hdr_pos, hdr_pos_next;
  logic        in_sent, in_sent_next;
  logic [3:0]  fld, fld_next;
  logic [3:0]  chr, chr_next;
  logic [47:0] time_chars, time_chars_next;
  logic        status_valid, status_valid_next;
  acc_t        lat_acc, lat_acc_next;
  logic [7:0]  lat_hemi, lat_hemi_next;
  acc_t        lon_acc, lon_acc_next;
  logic [7:0]  lon_hemi, lon_hemi_next;
  logic [SPD_W-1:0] spd_acc, spd_acc_next;
  logic [2:0]  phase, phase_next;
  logic [55:0] course_chars, course_chars_next;

  // Shared number unit.
  logic        take;
  logic [7:0]  b;
  logic        is_num, num_step, num_wr, is_digit;
  acc_t        num_acc, num_cap, num_val, settled, dig_val;
  logic [2:0]  num_frac;
  logic [33:0] dig_sum;
  logic        snap_load;
  logic        status_eff;
  logic [7:0]  lat_hemi_eff, lon_hemi_eff;

  function automatic acc_t settle(input acc_t acc, input logic [2:0] ph,
                                  input logic [2:0] frac, input acc_t cap);
    logic [2:0]  taken;
    logic [43:0] prod;
    taken = (ph == PH_INT) ? 3'd0 : ph - 3'd1;
    prod  = 44'(acc) * 44'(pow10(frac - taken));
    if (ph == PH_DONE) begin
      settle = acc;
    end else if (prod > 44'(cap)) begin
      settle = cap;
    end else begin
      settle = prod[ACC_W-1:0];
    end
  endfunction

  // Pipeline stages.
  logic        s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic        s1_free, s2_free, s3_free, s4_free, out_free;

  logic        s1_fix, s2_fix, s3_fix, s4_fix;
  logic [47:0] s1_time, s2_time, s3_time, s4_time;
  logic [7:0]  s1_lath, s2_lath, s3_lath, s4_lath;
  logic [7:0]  s1_lonh, s2_lonh, s3_lonh, s4_lonh;
  logic [55:0] s1_course, s2_course, s3_course, s4_course;
  acc_t        s1_lat, s1_lon, s2_lat, s2_lon;
  logic [SPD_W-1:0] s1_spd;
  logic [9:0]  s2_latq, s2_lonq, s3_latq, s3_lonq, s4_latq, s4_lonq;
  logic        s2_big, s3_big;
  logic [27:0] s2_spdp;
  logic [19:0] s3_latrp, s3_lonrp;
  logic [17:0] s3_spd, s4_spd;
  logic [14:0] s4_latf, s4_lonf;

  logic [60:0] lat_mul, lon_mul;
  logic [56:0] spd_mul;
  logic [40:0] latf_mul, lonf_mul;
  logic [23:0] lat_deg, lon_deg;

  logic        out_fix;
  logic [47:0] out_time;
  logic [19:0] out_lat;
  logic [7:0]  out_lath;
  logic [20:0] out_lon;
  logic [7:0]  out_lonh;
  logic [17:0] out_spd;
  logic [55:0] out_course;

  assign out_free = !out_valid || report.ready;
  assign s4_free  = !s4_valid || out_free;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign rx.ready = s1_free;

  assign take = rx.valid && rx.ready;
  assign b    = rx.rx_byte;

  // Number unit operand selection by field.
  always_comb begin
    is_num   = (fld == FLD_LAT) || (fld == FLD_LON) || (fld == FLD_SPEED);
    num_frac = (fld == FLD_SPEED) ? SPD_FRAC : POS_FRAC;
    num_cap  = (fld == FLD_SPEED) ? SPD_CAP : POS_CAP;
    case (fld)
      FLD_LAT:   num_acc = lat_acc;
      FLD_LON:   num_acc = lon_acc;
      FLD_SPEED: num_acc = ACC_W'(spd_acc);
      default:   num_acc = '0;
    endcase
    settled  = settle(num_acc, phase, num_frac, num_cap);
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    dig_sum  = 34'(num_acc) * 34'(10) + 34'(b - CH_ZERO);
    dig_val  = (dig_sum > 34'(num_cap)) ? num_cap : dig_sum[ACC_W-1:0];

    // Status and hemisphere bytes are the first byte after their comma,
    // whatever it is, so they are taken before the newline check.
    status_eff   = status_valid;
    lat_hemi_eff = lat_hemi;
    lon_hemi_eff = lon_hemi;
    if (in_sent && (chr == 4'd0)) begin
      if (fld == FLD_STATUS) status_eff = (b == CH_A);
      if (fld == FLD_NS) lat_hemi_eff = b;
      if (fld == FLD_EW) lon_hemi_eff = b;
    end
  end

  // Per-character parser.
  always_comb begin
    hdr_pos_next      = hdr_pos;
    in_sent_next      = in_sent;
    fld_next          = fld;
    chr_next          = chr;
    time_chars_next   = time_chars;
    status_valid_next = status_valid;
    lat_acc_next      = lat_acc;
    lat_hemi_next     = lat_hemi;
    lon_acc_next      = lon_acc;
    lon_hemi_next     = lon_hemi;
    spd_acc_next      = spd_acc;
    phase_next        = phase;
    course_chars_next = course_chars;
    snap_load         = 1'b0;
    num_step          = 1'b0;
    num_wr            = 1'b0;
    num_val           = settled;

    if (take) begin
      if (!in_sent) begin
        if ((hdr_pos <= HDR_LAST) && (b == hdr_byte(hdr_pos))) begin
          if (hdr_pos == HDR_LAST) begin
            // Header complete: start a fresh sentence.
            hdr_pos_next      = 3'd0;
            in_sent_next      = 1'b1;
            fld_next          = '0;
            chr_next          = '0;
            time_chars_next   = '0;
            status_valid_next = 1'b0;
            lat_acc_next      = '0;
            lat_hemi_next     = '0;
            lon_acc_next      = '0;
            lon_hemi_next     = '0;
            spd_acc_next      = '0;
            phase_next        = PH_INT;
            course_chars_next = '0;
          end else begin
            hdr_pos_next = hdr_pos + 3'd1;
          end
        end else begin
          hdr_pos_next = (b == CH_DOLLAR) ? 3'd1 : 3'd0;
        end
      end else begin
        status_valid_next = status_eff;
        lat_hemi_next     = lat_hemi_eff;
        lon_hemi_next     = lon_hemi_eff;
        if (b == CH_NL) begin
          num_wr       = is_num;
          phase_next   = PH_INT;
          in_sent_next = 1'b0;
          hdr_pos_next = 3'd0;
          snap_load    = 1'b1;
        end else if (b == CH_COMMA) begin
          num_wr     = is_num;
          phase_next = PH_INT;
          if (fld != CNT_MAX) fld_next = fld + 4'd1;
          chr_next   = '0;
        end else begin
          case (fld)
            FLD_TIME: begin
              for (int i = 0; i < TIME_LIM; i++) begin
                if (chr == 4'(i)) time_chars_next[8*(5-i) +: 8] = b;
              end
            end
            FLD_LAT:   num_step = (chr < 4'(LAT_CHARS));
            FLD_LON:   num_step = (chr < 4'(LON_CHARS));
            FLD_SPEED: num_step = 1'b1;
            FLD_COURSE: begin
              for (int i = 0; i < COURSE_LIM; i++) begin
                if (chr == 4'(i)) course_chars_next[8*(6-i) +: 8] = b;
              end
            end
            default: ;
          endcase
          if (num_step && (phase != PH_DONE)) begin
            if (is_digit) begin
              if ((phase == PH_INT) || ((phase - 3'd1) < num_frac)) begin
                num_wr  = 1'b1;
                num_val = dig_val;
                if (phase != PH_INT) phase_next = phase + 3'd1;
              end
            end else if ((b == CH_DOT) && (phase == PH_INT)) begin
              phase_next = PH_FRAC;
            end else begin
              // Any other byte ends the number with its value scaled.
              num_wr     = 1'b1;
              phase_next = PH_DONE;
            end
          end
          if (chr != CNT_MAX) chr_next = chr + 4'd1;
        end
      end
    end

    if (num_wr) begin
      case (fld)
        FLD_LAT:   lat_acc_next = num_val;
        FLD_LON:   lon_acc_next = num_val;
        FLD_SPEED: spd_acc_next = num_val[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos      <= '0;
      in_sent      <= 1'b0;
      fld          <= '0;
      chr          <= '0;
      time_chars   <= '0;
      status_valid <= 1'b0;
      lat_acc      <= '0;
      lat_hemi     <= '0;
      lon_acc      <= '0;
      lon_hemi     <= '0;
      spd_acc      <= '0;
      phase        <= PH_INT;
      course_chars <= '0;
    end else begin
      hdr_pos      <= hdr_pos_next;
      in_sent      <= in_sent_next;
      fld          <= fld_next;
      chr          <= chr_next;
      time_chars   <= time_chars_next;
      status_valid <= status_valid_next;
      lat_acc      <= lat_acc_next;
      lat_hemi     <= lat_hemi_next;
      lon_acc      <= lon_acc_next;
      lon_hemi     <= lon_hemi_next;
      spd_acc      <= spd_acc_next;
      phase        <= phase_next;
      course_chars <= course_chars_next;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free)  s1_valid  <= snap_load;
      if (s2_free)  s2_valid  <= s1_valid;
      if (s3_free)  s3_valid  <= s2_valid;
      if (s4_free)  s4_valid  <= s3_valid;
      if (out_free) out_valid <= s4_valid;
    end
  end

  // Snapshot: the field still open at the newline is taken in its settled form.
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_fix    <= status_eff;
      s1_time   <= time_chars;
      s1_lat    <= (fld == FLD_LAT) ? settled : lat_acc;
      s1_lath   <= lat_hemi_eff;
      s1_lon    <= (fld == FLD_LON) ? settled : lon_acc;
      s1_lonh   <= lon_hemi_eff;
      s1_spd    <= (fld == FLD_SPEED) ? settled[SPD_W-1:0] : spd_acc;
      s1_course <= course_chars;
    end
  end

  // Stage 2: whole degrees by reciprocal of 10^6; speed times 1.852 in 10^-3.
  assign lat_mul = 61'(s1_lat) * 61'(RECIP_1E6);
  assign lon_mul = 61'(s1_lon) * 61'(RECIP_1E6);

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_fix    <= s1_fix;
      s2_time   <= s1_time;
      s2_lath   <= s1_lath;
      s2_lonh   <= s1_lonh;
      s2_course <= s1_course;
      s2_lat    <= s1_lat;
      s2_lon    <= s1_lon;
      s2_latq   <= lat_mul[59:50];
      s2_lonq   <= lon_mul[59:50];
      s2_big    <= (s1_spd > SPD_SAT_KNOTS);
      s2_spdp   <= 28'(s1_spd[16:0]) * 28'(1852) + 28'd500;
    end
  end

  // Stage 3: minutes remainder plus half a step; speed divided by 1000.
  assign spd_mul = 57'(s2_spdp) * 57'(RECIP_1E3);

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_fix    <= s2_fix;
      s3_time   <= s2_time;
      s3_lath   <= s2_lath;
      s3_lonh   <= s2_lonh;
      s3_course <= s2_course;
      s3_latq   <= s2_latq;
      s3_lonq   <= s2_lonq;
      s3_latrp  <= 20'(s2_lat - 30'(s2_latq) * 30'(1000000) + 30'd30);
      s3_lonrp  <= 20'(s2_lon - 30'(s2_lonq) * 30'(1000000) + 30'd30);
      s3_big    <= s2_big;
      s3_spd    <= spd_mul[55:38];
    end
  end

  // Stage 4: minutes divided by 60; speed saturated at SPD_MAX.
  assign latf_mul = 41'(s3_latrp) * 41'(RECIP_60);
  assign lonf_mul = 41'(s3_lonrp) * 41'(RECIP_60);

  always_ff @(posedge clk) begin
    if (s4_free) begin
      s4_fix    <= s3_fix;
      s4_time   <= s3_time;
      s4_lath   <= s3_lath;
      s4_lonh   <= s3_lonh;
      s4_course <= s3_course;
      s4_latq   <= s3_latq;
      s4_lonq   <= s3_lonq;
      s4_latf   <= latf_mul[40:26];
      s4_lonf   <= lonf_mul[40:26];
      s4_spd    <= (s3_big || (s3_spd > SPD_MAX)) ? SPD_MAX : s3_spd;
    end
  end

  // Report register: degrees assembled, saturated, and blanked without a fix.
  assign lat_deg = 24'(s4_latq) * 24'(10000) + 24'(s4_latf);
  assign lon_deg = 24'(s4_lonq) * 24'(10000) + 24'(s4_lonf);

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_fix    <= s4_fix;
      out_time   <= s4_time;
      out_lat    <= !s4_fix ? '0 : (lat_deg > 24'(LAT_MAX)) ? LAT_MAX : lat_deg[19:0];
      out_lon    <= !s4_fix ? '0 : (lon_deg > 24'(LON_MAX)) ? LON_MAX : lon_deg[20:0];
      out_lath   <= s4_fix ? s4_lath : '0;
      out_lonh   <= s4_fix ? s4_lonh : '0;
      out_spd    <= s4_fix ? s4_spd : '0;
      out_course <= s4_fix ? s4_course : '0;
    end
  end

  assign report.valid          = out_valid;
  assign report.fix_valid      = out_fix;
  assign report.utc_time_text  = out_time;
  assign report.lat_deg_e4     = out_lat;
  assign report.lat_hemisphere = out_lath;
  assign report.lon_deg_e4     = out_lon;
  assign report.lon_hemisphere = out_lonh;
  assign report.speed_kmh_e2   = out_spd;
  assign report.course_text    = out_course;

endmodule

`default_nettype wire

>>> hdl/nrmc_checker.sv
// Port-level checks for the NMEA RMC parser and the bind that attaches them.
// Depends on nrmc_pkg and the top level nmea_rmc_sentence_parser.
`default_nettype none

module nrmc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        fix_valid,
  input  logic [47:0] utc_time_text,
  input  logic [19:0] lat_deg_e4,
  input  logic [7:0]  lat_hemisphere,
  input  logic [20:0] lon_deg_e4,
  input  logic [7:0]  lon_hemisphere,
  input  logic [17:0] speed_kmh_e2,
  input  logic [55:0] course_text
);
  import nrmc_pkg::*;

  // A stalled report transaction holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(lat_deg_e4) && $stable(lon_deg_e4)
      && $stable(speed_kmh_e2) && $stable(utc_time_text) && $stable(fix_valid)))
    else $error("report payload changed during stall");

  // Reset leaves no report pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("report valid right after reset");

  // Without a fix, all position, speed and course fields are blank.
  a_blank_no_fix: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fix_valid) |-> (lat_deg_e4 == '0 && lon_deg_e4 == '0
      && lat_hemisphere == '0 && lon_hemisphere == '0 && speed_kmh_e2 == '0
      && course_text == '0))
    else $error("fields not blank without a fix");

  // Converted values never exceed their saturation limits.
  a_saturation: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lat_deg_e4 <= LAT_MAX && lon_deg_e4 <= LON_MAX
      && speed_kmh_e2 <= SPD_MAX))
    else $error("converted value above its limit");

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (report.valid),
  .out_ready      (report.ready),
  .fix_valid      (report.fix_valid),
  .utc_time_text  (report.utc_time_text),
  .lat_deg_e4     (report.lat_deg_e4),
  .lat_hemisphere (report.lat_hemisphere),
  .lon_deg_e4     (report.lon_deg_e4),
  .lon_hemisphere (report.lon_hemisphere),
  .speed_kmh_e2   (report.speed_kmh_e2),
  .course_text    (report.course_text)
);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the NMEA RMC sentence parser: directed and random
// character streams, a scoreboard class that predicts each sentence report.
// Depends on nrmc_pkg, nrmc_if and nmea_rmc_sentence_parser.
`timescale 1ns / 1ps

module testbench;
  import nrmc_pkg::*;

  typedef struct packed {
    logic        fix_valid;
    logic [47:0] utc_time_text;
    logic [19:0] lat_deg_e4;
    logic [7:0]  lat_hemisphere;
    logic [20:0] lon_deg_e4;
    logic [7:0]  lon_hemisphere;
    logic [17:0] speed_kmh_e2;
    logic [55:0] course_text;
  } rmc_report_t;

  localparam logic [47:0] HDR_TEXT       = "$GPRMC";
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          LONG_HOLD      = 400;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          MAX_SHOWN      = 10;

  // Predicts one report per RMC sentence from the accepted character stream.
  class rmc_scoreboard;
    logic [2:0]  hdr_pos;
    logic        in_sentence;
    logic [3:0]  field_idx;
    logic [3:0]  field_chars;
    logic [47:0] utc_chars;
    logic        status_ok;
    logic [31:0] lat_acc;
    logic [7:0]  lat_hemi;
    logic [33:0] lon_acc;
    logic [7:0]  lon_hemi;
    logic [23:0] knots_acc;
    logic [2:0]  num_phase;
    logic [55:0] course_chars;
    rmc_report_t expected_reports[$];
    int          mismatch_total;
    int          reports_queued;
    int          reports_seen;
    int          valid_fixes;

    function void clear_fields();
      field_idx = '0; field_chars = '0; utc_chars = '0; status_ok = 1'b0;
      lat_acc = '0; lat_hemi = '0; lon_acc = '0; lon_hemi = '0;
      knots_acc = '0; num_phase = PH_INT; course_chars = '0;
    endfunction

    function void reset_state();
      hdr_pos = '0;
      in_sentence = 1'b0;
      clear_fields();
      expected_reports.delete();
      mismatch_total = 0; reports_queued = 0; reports_seen = 0; valid_fixes = 0;
    endfunction

    function int outstanding();
      return expected_reports.size();
    endfunction

    // Brings a number to exactly frac fraction digits unless it already ended.
    function logic [63:0] scale_up(logic [63:0] acc, logic [2:0] phase, logic [2:0] frac,
                                   logic [63:0] cap);
      int taken;
      if (phase == PH_DONE) return acc;
      taken = (phase == PH_INT) ? 0 : int'(phase) - 1;
      while (taken < frac) begin
        acc = acc * 10;
        if (acc > cap) acc = cap;
        taken++;
      end
      return acc;
    endfunction

    function logic [63:0] add_digit(logic [63:0] acc, logic [2:0] frac, logic [63:0] cap,
                                    logic [7:0] b);
      logic [63:0] v;
      if (num_phase == PH_DONE) return acc;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        if (num_phase == PH_INT || (num_phase - PH_FRAC) < frac) begin
          v = acc * 10 + 64'(b - CH_ZERO);
          acc = (v > cap) ? cap : v;
          if (num_phase != PH_INT) num_phase = num_phase + 3'd1;
        end
      end else if (b == CH_DOT && num_phase == PH_INT) begin
        num_phase = PH_FRAC;
      end else begin
        acc = scale_up(acc, num_phase, frac, cap);
        num_phase = PH_DONE;
      end
      return acc;
    endfunction

    function void close_number();
      case (field_idx)
        FLD_LAT:   lat_acc   = 32'(scale_up(64'(lat_acc), num_phase, POS_FRAC, 64'(POS_CAP)));
        FLD_LON:   lon_acc   = 34'(scale_up(64'(lon_acc), num_phase, POS_FRAC, 64'(POS_CAP)));
        FLD_SPEED: knots_acc = 24'(scale_up(64'(knots_acc), num_phase, SPD_FRAC,
                                            64'(SPD_CAP)));
        default: ;
      endcase
      num_phase = PH_INT;
    endfunction

    // ddmm.mmmm in units of 1e-4 to degrees times 1e4, halves rounded up.
    function logic [63:0] to_deg_e4(logic [63:0] v, logic [63:0] lim);
      logic [63:0] r;
      r = (v / 64'd1000000) * 64'd10000 + ((v % 64'd1000000) + 64'd30) / 64'd60;
      return (r > lim) ? lim : r;
    endfunction

    function void note_input(logic [7:0] b);
      logic [3:0]  k;
      logic [63:0] spd;
      rmc_report_t r;
      if (!in_sentence) begin
        if (hdr_pos < 6 && b == HDR_TEXT[8*(5-hdr_pos) +: 8]) begin
          hdr_pos = hdr_pos + 3'd1;
          if (hdr_pos == 6) begin
            hdr_pos = '0;
            in_sentence = 1'b1;
            clear_fields();
          end
        end else begin
          hdr_pos = (b == CH_DOLLAR) ? 3'd1 : 3'd0;
        end
        return;
      end
      k = field_chars;
      if (k == 0) begin
        case (field_idx)
          FLD_STATUS: status_ok = (b == CH_A);
          FLD_NS:     lat_hemi = b;
          FLD_EW:     lon_hemi = b;
          default: ;
        endcase
      end
      if (b == CH_NL) begin
        close_number();
        r = '0;
        r.fix_valid = status_ok;
        r.utc_time_text = utc_chars;
        if (status_ok) begin
          r.lat_deg_e4 = 20'(to_deg_e4(64'(lat_acc), 64'(LAT_MAX)));
          r.lat_hemisphere = lat_hemi;
          r.lon_deg_e4 = 21'(to_deg_e4(64'(lon_acc), 64'(LON_MAX)));
          r.lon_hemisphere = lon_hemi;
          spd = 64'(knots_acc);
          spd = (spd * 64'd1852 + 64'd500) / 64'd1000;
          r.speed_kmh_e2 = (spd > SPD_MAX) ? SPD_MAX : spd[17:0];
          r.course_text = course_chars;
        end
        expected_reports.push_back(r);
        reports_queued++;
        in_sentence = 1'b0;
        hdr_pos = '0;
        return;
      end
      if (b == CH_COMMA) begin
        close_number();
        if (field_idx < CNT_MAX) field_idx = field_idx + 4'd1;
        field_chars = '0;
        return;
      end
      case (field_idx)
        FLD_TIME:   if (k < TIME_LIM) utc_chars[8*(5-k) +: 8] = b;
        FLD_LAT:    if (k < LAT_CHARS)
          lat_acc = 32'(add_digit(64'(lat_acc), POS_FRAC, 64'(POS_CAP), b));
        FLD_LON:    if (k < LON_CHARS)
          lon_acc = 34'(add_digit(64'(lon_acc), POS_FRAC, 64'(POS_CAP), b));
        FLD_SPEED:  knots_acc = 24'(add_digit(64'(knots_acc), SPD_FRAC, 64'(SPD_CAP), b));
        FLD_COURSE: if (k < COURSE_LIM) course_chars[8*(6-k) +: 8] = b;
        default: ;
      endcase
      if (field_chars < CNT_MAX) field_chars = field_chars + 4'd1;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatch_total++;
        if (mismatch_total <= MAX_SHOWN)
          $display("report %0d, %s: expected %h, got %h", reports_seen, name, want, got);
      end
    endfunction

    function void check_report(rmc_report_t got);
      rmc_report_t want;
      if (expected_reports.size() == 0) begin
        mismatch_total++;
        if (mismatch_total <= MAX_SHOWN) $display("report with none expected: %h", got);
        return;
      end
      want = expected_reports.pop_front();
      reports_seen++;
      if (want.fix_valid) valid_fixes++;
      compare_field("fix_valid", 64'(want.fix_valid), 64'(got.fix_valid));
      compare_field("utc_time_text", 64'(want.utc_time_text), 64'(got.utc_time_text));
      compare_field("lat_deg_e4", 64'(want.lat_deg_e4), 64'(got.lat_deg_e4));
      compare_field("lat_hemisphere", 64'(want.lat_hemisphere), 64'(got.lat_hemisphere));
      compare_field("lon_deg_e4", 64'(want.lon_deg_e4), 64'(got.lon_deg_e4));
      compare_field("lon_hemisphere", 64'(want.lon_hemisphere), 64'(got.lon_hemisphere));
      compare_field("speed_kmh_e2", 64'(want.speed_kmh_e2), 64'(got.speed_kmh_e2));
      compare_field("course_text", 64'(want.course_text), 64'(got.course_text));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  nrmc_rx_if     rx_ch ();
  nrmc_report_if rep_ch ();

  nmea_rmc_sentence_parser dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .report (rep_ch)
  );

  rmc_scoreboard sb;
  rmc_report_t   seen_report;
  logic [7:0]    line_buf[$];
  bit            idle_on = 1'b1;
  bit            long_hold_req = 1'b0;
  int            bytes_sent = 0;
  int            idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Line construction helpers.
  function void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function void put_digits(int n);
    for (int i = 0; i < n; i++) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function void put_number(int max_int, int max_frac);
    logic [7:0] junk;
    put_digits($urandom_range(0, max_int));
    if ($urandom_range(0, 4) != 0) begin
      line_buf.push_back(CH_DOT);
      put_digits($urandom_range(0, max_frac));
    end
    if ($urandom_range(0, 11) == 0) begin
      junk = 8'($urandom_range(0, 255));
      line_buf.push_back(junk);
      put_digits($urandom_range(0, 3));
    end
  endfunction

  function void put_text_field(int len);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'(CH_ZERO + $urandom_range(0, 9));
      line_buf.push_back(c);
    end
  endfunction

  function void put_hemisphere(string a, string b);
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0, 1:    put_text(a);
      2, 3:    put_text(b);
      4:       begin c = 8'($urandom_range(0, 255)); line_buf.push_back(c); end
      default: ;
    endcase
  endfunction

  function void build_short_line();
    put_text("$GPRMC,");
    put_digits($urandom_range(1, 3));
    put_text(($urandom_range(0, 3) == 0) ? ",V," : ",A,");
    put_number(4, 4);
    line_buf.push_back(CH_NL);
  endfunction

  function void build_full_line();
    logic [7:0] c;
    int         cut;
    if ($urandom_range(0, 9) == 0) put_text("$GPR");
    put_text("$GPRMC,");
    put_text_field($urandom_range(0, 9));
    line_buf.push_back(CH_COMMA);
    case ($urandom_range(0, 9))
      0:       ;
      1:       put_text("V");
      2:       begin c = 8'($urandom_range(0, 255)); line_buf.push_back(c); end
      default: put_text("A");
    endcase
    line_buf.push_back(CH_COMMA);
    put_number(($urandom_range(0, 7) == 0) ? 11 : 4, 6);
    line_buf.push_back(CH_COMMA);
    put_hemisphere("N", "S");
    line_buf.push_back(CH_COMMA);
    put_number(($urandom_range(0, 7) == 0) ? 12 : 5, 6);
    line_buf.push_back(CH_COMMA);
    put_hemisphere("E", "W");
    line_buf.push_back(CH_COMMA);
    put_number(($urandom_range(0, 7) == 0) ? 8 : 3, 4);
    line_buf.push_back(CH_COMMA);
    put_text_field($urandom_range(0, 10));
    if ($urandom_range(0, 1) == 0) put_text(",230394,003.1,W*6A\r");
    line_buf.push_back(CH_NL);
    // Now and then the sentence is cut short by an early newline.
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(11, line_buf.size() - 1);
      while (line_buf.size() > cut) void'(line_buf.pop_back());
      line_buf.push_back(CH_NL);
    end
  endfunction

  function void build_random_line();
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0: begin
        repeat ($urandom_range(1, 20)) begin
          c = 8'($urandom_range(0, 255));
          line_buf.push_back(c);
        end
      end
      1: begin
        put_text(($urandom_range(0, 1) == 0) ? "$GPGGA," : "$GPRMB,");
        put_digits(6);
        put_text(",4807.038,N,,\n");
      end
      2, 3: build_short_line();
      default: build_full_line();
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) begin
      send_byte(line_buf[i]);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        rx_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
    line_buf.delete();
  endtask

  // The first edge lets the monitor note the last accepted character.
  task automatic wait_for_reports();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Report side: random stalls, plus one long hold-off on request.
  initial begin
    rep_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        rep_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        rep_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rep_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        rep_ch.ready <= 1'b1;
      end else begin
        rep_ch.ready <= 1'b1;
      end
    end
  end

  // Transaction monitor and watchdog. Reports are checked before the input of
  // the same edge is noted, so the oldest expectation is always the one used.
  always @(posedge clk) begin
    if (!rst) begin
      if (rep_ch.valid && rep_ch.ready) begin
        seen_report = {rep_ch.fix_valid, rep_ch.utc_time_text, rep_ch.lat_deg_e4,
                       rep_ch.lat_hemisphere, rep_ch.lon_deg_e4, rep_ch.lon_hemisphere,
                       rep_ch.speed_kmh_e2, rep_ch.course_text};
        sb.check_report(seen_report);
      end
      if (rx_ch.valid && rx_ch.ready) sb.note_input(rx_ch.rx_byte);
      if ((rx_ch.valid && rx_ch.ready) || (rep_ch.valid && rep_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    string directed_lines[$];
    int    failures;
    sb = new();
    sb.reset_state();
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_lines = '{
      "$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n",
      "$GPRMC,235959,V,4807.038,N,01131.000,E,022.4,084.4,230394,,*00\n",
      "$GPRMC,,,,,,,,\n",
      "$GPRMC,000000,A,9000.0000,S,18000.0000,W,0.00,000.0\n",
      "$GPRMC,1,A,9959.9999,N,99999999999.99,E,99999.99,359.9\n",
      "$GPRMC,1,A,4575.0000,N,00099.9999,E,1.239,1\n",
      "$GPRMC,12,A,12.34.56,N,12a34,E,1.2.3,\n",
      "$GPRMC,123,A,4807.038123456,N,01131.00012345,E,.5,12345678901\n",
      "$GPRMC,1235191234,A,0.00003,,0000.00005,,0.005,7\n",
      "$GPRMC,6,A,0059.99995,N,17959.99995,W,0.01,x\n",
      "$GPRMC,8,A,00000000000000000000001234,N,0,E,0.27,1\n",
      "$GPRMC,1,A,4807.038,\n",
      "$GPRMC,1,A,\n",
      "$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n",
      "$GP$GPRMC,1,A$x,12,N,,,,\n",
      "$GPRM$GPRMC,2,A,\n",
      "$GPRMC,3,\n",
      "$GPRMC,4,a,1,N,1,E,1,1\n",
      "$GPRMC,,,,,,,,,,,,,,,,,,,,,,,\n",
      "noise $GPRMC,5,A,1,N,2,E,3,4\n"
    };
    foreach (directed_lines[i]) begin
      put_text(directed_lines[i]);
      send_line();
    end
    // Extreme byte values inside the text fields.
    put_text("$GPRMC,");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    put_text(",A,1,");
    line_buf.push_back(8'hFF);
    put_text(",2,");
    line_buf.push_back(8'h80);
    put_text(",3,");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h7F);
    line_buf.push_back(CH_NL);
    send_line();
    wait_for_reports();

    while (bytes_sent < 700) begin
      build_random_line();
      send_line();
    end

    // Back-pressure: reports held off while short sentences keep coming.
    idle_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (40) begin
      build_short_line();
      send_line();
    end
    wait_for_reports();
    idle_on = 1'b1;

    while (bytes_sent < 1350) begin
      build_random_line();
      send_line();
    end
    idle_on = 1'b0;
    while (bytes_sent < 1650 || sb.reports_queued < 60) begin
      build_random_line();
      send_line();
    end

    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures = sb.mismatch_total + sb.outstanding();
    $display("Run covered %0d received bytes and %0d sentence reports, %0d with a valid fix.",
             bytes_sent, sb.reports_seen, sb.valid_fixes);
    $display("Mismatched fields and unexpected reports: %0d.", failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
